FILE: rtl/core/dmpc_pkg.sv
// package: shared types, constants and state codes for the position cache
`timescale 1ns / 1ps
package dmpc_pkg;

  localparam int unsigned TableSlots = 65536;
  localparam int unsigned DepthLimit = 256;
  localparam int unsigned SlotW = $clog2(TableSlots);
  localparam int unsigned KeyW = 64;
  localparam int unsigned CntW = $clog2(KeyW + 1);

  typedef enum logic [1:0] {
    CfgEntries = 2'd0,
    CfgAdjust  = 2'd1,
    CfgMate    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDiv,
    StRead,
    StCheck,
    StOut
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [63:0] key;
    logic [7:0]  depth;
    logic [7:0]  ply;
    logic [1:0]  flag;
    logic signed [31:0] value;
    logic [15:0] best_move;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  found_depth;
    logic [1:0]  found_flag;
    logic signed [31:0] found_value;
    logic [15:0] found_move;
  } out_item_t;

  typedef struct packed {
    logic clear;     // zero one slot of the clearing pass
    logic load;      // capture item, start division
    logic div_step;  // one restoring step
    logic mem_read;  // read the slot
    logic mem_write; // write the slot (store)
    logic out_load;  // capture probe result
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic is_probe;
    logic same_entry;
  } dp_sts_t;

  // mate shift with saturation; dir_up moves away from zero
  function automatic logic signed [31:0] mate_shift(
      input logic signed [31:0] v, input logic [7:0] ply,
      input logic [30:0] mate, input logic dir_up);
    logic signed [33:0] vx;
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] px;
    logic signed [33:0] r;
    vx = 34'(v);
    px = 34'(ply);
    lo = 34'(DepthLimit) - 34'(mate);
    hi = 34'(mate) - 34'(DepthLimit);
    r  = vx;
    if (vx < lo) r = dir_up ? vx - px : vx + px;
    else if (vx > hi) r = dir_up ? vx + px : vx - px;
    if (r > 34'sh07FFFFFFF) mate_shift = 32'sh7FFFFFFF;
    else if (r < -34'sh080000000) mate_shift = 32'sh80000000;
    else mate_shift = r[31:0];
  endfunction

endpackage

FILE: rtl/core/dmpc_ctrl.sv
// controller: sequences clearing pass, divide, slot read, update and result transfer
`timescale 1ns / 1ps
module dmpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  dmpc_pkg::dp_sts_t  sts_i,
  output dmpc_pkg::dp_cmd_t  cmd_o
);
  dmpc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dmpc_pkg::StClear;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      dmpc_pkg::StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) state_d = dmpc_pkg::StIdle;
      end
      dmpc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = dmpc_pkg::StDiv;
        end
      end
      dmpc_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = dmpc_pkg::StRead;
      end
      dmpc_pkg::StRead: begin
        cmd_o.mem_read = 1'b1;
        state_d = dmpc_pkg::StCheck;
      end
      dmpc_pkg::StCheck: begin
        if (sts_i.is_probe) begin
          cmd_o.out_load = 1'b1;
          state_d = dmpc_pkg::StOut;
        end else begin
          cmd_o.mem_write = !sts_i.same_entry;
          state_d = dmpc_pkg::StIdle;
        end
      end
      dmpc_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = dmpc_pkg::StIdle;
      end
      default: state_d = dmpc_pkg::StIdle;
    endcase
  end
endmodule

FILE: rtl/core/dmpc_dp.sv
// datapath: key remainder, slot memory, mate adjustment, result register
`timescale 1ns / 1ps
module dmpc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dmpc_pkg::in_item_t  in_i,
  input  logic [16:0]         entries_i,
  input  logic                adjust_i,
  input  logic [30:0]         mate_i,
  input  dmpc_pkg::dp_cmd_t   cmd_i,
  output dmpc_pkg::dp_sts_t   sts_o,
  output dmpc_pkg::out_item_t out_o
);
  localparam int unsigned SlotW = dmpc_pkg::SlotW;
  localparam int unsigned EntW = 122;

  dmpc_pkg::in_item_t item_q;
  logic [dmpc_pkg::KeyW-1:0] quo_q;
  logic [SlotW:0] rem_q;
  logic [SlotW:0] mod_q;
  logic [dmpc_pkg::CntW-1:0] cnt_q;
  logic [SlotW-1:0] clr_q;
  logic [EntW-1:0] mem [dmpc_pkg::TableSlots];
  logic [EntW-1:0] rd_q;
  logic [SlotW+1:0] trial;
  logic [SlotW:0] rem_sh;
  logic [16:0] n_eff;
  logic [EntW-1:0] entry;
  logic [63:0] s_key;
  logic [7:0] s_depth;
  logic [1:0] s_flag;
  logic signed [31:0] s_value;
  logic [15:0] s_move;
  logic [SlotW-1:0] slot;

  always_comb begin
    n_eff = entries_i;
    if (entries_i == 17'd0) n_eff = 17'd1;
    else if (entries_i > 17'(dmpc_pkg::TableSlots)) n_eff = 17'(dmpc_pkg::TableSlots);
  end

  assign rem_sh = {rem_q[SlotW-1:0], quo_q[dmpc_pkg::KeyW-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, mod_q};
  assign slot = rem_q[SlotW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_i;
      quo_q <= in_i.key;
      rem_q <= '0;
      mod_q <= (SlotW+1)'(n_eff);
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[dmpc_pkg::KeyW-2:0], 1'b0};
      rem_q <= trial[SlotW+1] ? rem_sh : trial[SlotW:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.load) cnt_q <= '0;
    else if (cmd_i.div_step) cnt_q <= cnt_q + 1'b1;
  end
  assign sts_o.div_done = cmd_i.div_step && (cnt_q == dmpc_pkg::CntW'(dmpc_pkg::KeyW - 1));

  // clearing pass address, one slot per cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clear) clr_q <= clr_q + 1'b1;
  end
  assign sts_o.clear_done = cmd_i.clear && (clr_q == '1);

  always_comb begin
    entry = {item_q.key, item_q.depth, item_q.flag,
             adjust_i ? dmpc_pkg::mate_shift(item_q.value, item_q.ply, mate_i, 1'b1)
                      : item_q.value,
             item_q.best_move};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) mem[clr_q] <= '0;
    else if (cmd_i.mem_write) mem[slot] <= entry;
    if (cmd_i.mem_read) rd_q <= mem[slot];
  end

  assign {s_key, s_depth, s_flag, s_value, s_move} = rd_q;
  assign sts_o.is_probe = item_q.kind;
  assign sts_o.same_entry = (s_key == item_q.key) && (s_depth == item_q.depth);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (s_key == item_q.key) begin
        out_o.hit <= 1'b1;
        out_o.found_depth <= s_depth;
        out_o.found_flag <= s_flag;
        out_o.found_value <= adjust_i
            ? dmpc_pkg::mate_shift(s_value, item_q.ply, mate_i, 1'b0) : s_value;
        out_o.found_move <= s_move;
      end else begin
        out_o <= '0;
      end
    end
  end
endmodule

FILE: rtl/core/direct_mapped_position_cache_core.sv
// top level: position cache with config registers, controller and datapath
`timescale 1ns / 1ps
// channel | direction | payload          | handshake
// in      | input     | in_item_t        | in_valid_i / in_ready_o
// out     | output    | out_item_t       | out_valid_o / out_ready_i
// cfg     | input     | index, data      | cfg_valid_i / cfg_ready_o
// load at the input transfer, 64 restoring divide steps (the key remainder),
// slot read, then check: a store commits in the check state unless the slot
// already holds the same key and depth; the next input transfer can follow
// in the cycle after the check. A probe result is loaded into the output
// register in the check state and waits there until its transfer; the next input
// can follow in the cycle after that transfer; no new item is taken meanwhile
// after reset a clearing pass zeroes every slot of the table with input held off
module direct_mapped_position_cache_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dmpc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dmpc_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  logic [16:0] entries_q;
  logic        adjust_q;
  logic [30:0] mate_q;
  dmpc_pkg::dp_cmd_t cmd;
  dmpc_pkg::dp_sts_t sts;

  // configuration always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= 17'd65536;
      adjust_q <= 1'b1;
      mate_q <= 31'd32000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dmpc_pkg::CfgEntries: entries_q <= cfg_data_i[16:0];
        dmpc_pkg::CfgAdjust:  adjust_q <= cfg_data_i[0];
        dmpc_pkg::CfgMate:    mate_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  dmpc_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .sts_i(sts), .cmd_o(cmd)
  );

  dmpc_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_data_i),
    .entries_i(entries_q), .adjust_i(adjust_q), .mate_i(mate_q),
    .cmd_i(cmd), .sts_o(sts), .out_o(out_data_o)
  );
endmodule
